FILE: design/pkrs_pkg.sv
// shared types and constants of the per-key request serializer
// no dependencies
package pkrs_pkg;
   localparam int NumEntries = 16;
   localparam int QueueDepth = 8;
   localparam int KeyBits    = 32;
   localparam int TagBits    = 8;
   localparam int EntryBits  = $clog2(NumEntries);
   localparam int PtrBits    = $clog2(QueueDepth);
   localparam int CntBits    = $clog2(QueueDepth + 1);
   localparam int ActBits    = $clog2(NumEntries + 1);

   typedef enum logic [2:0] {
      ACT_DISPATCH     = 3'd0,
      ACT_HELD         = 3'd1,
      ACT_REJ_KEY_FULL = 3'd2,
      ACT_REJ_NO_ENTRY = 3'd3,
      ACT_REPLY        = 3'd4,
      ACT_REPLY_UNKNWN = 3'd5,
      ACT_REPLY_NOHEAD = 3'd6
   } action_type;

   localparam logic OP_SUBMIT   = 1'b0;
   localparam logic OP_COMPLETE = 1'b1;

   localparam logic [0:0] REG_MAX_ACTIVE = 1'd0;
   localparam logic [0:0] REG_MAX_PER_KEY = 1'd1;

   // result of the key table lookup
   typedef struct packed {
      logic                 hit;
      logic [EntryBits-1:0] hit_idx;
      logic                 free;
      logic [EntryBits-1:0] free_idx;
   } lookup_type;
endpackage

FILE: design/pkrs_lookup.sv
// associative key match and lowest free entry search
// depends on pkrs_pkg
module pkrs_lookup (
   input  logic [pkrs_pkg::NumEntries-1:0]                    valid,
   input  logic [pkrs_pkg::NumEntries-1:0][pkrs_pkg::KeyBits-1:0] keys,
   input  logic [pkrs_pkg::KeyBits-1:0]                       key,
   output pkrs_pkg::lookup_type                               result
);
   // priority search, lowest index wins
   always_comb begin
      result = '0;
      for (int i = pkrs_pkg::NumEntries - 1; i >= 0; i--) begin
         if (valid[i] && keys[i] == key) begin
            result.hit     = 1'b1;
            result.hit_idx = i[pkrs_pkg::EntryBits-1:0];
         end
         if (!valid[i]) begin
            result.free     = 1'b1;
            result.free_idx = i[pkrs_pkg::EntryBits-1:0];
         end
      end
   end
endmodule

FILE: design/per_key_request_serializer_top.sv
// top level of the per-key request serializer: key table, per-key tag queues, csr port
// depends on pkrs_pkg and pkrs_lookup
// An item is registered at the edge where start is high and busy is low. It is worked
// out from the input register, and its first result is registered onto the result
// ports with rsp_valid. Items that give one result can follow one per cycle and
// leave busy low. A head completion that dispatches a waiting tag gives two results on
// consecutive cycles. busy is then high for one cycle because there is a single result
// port, and an item taken just behind it waits in the input register meanwhile.
// The receiver cannot stall: each result is shown for exactly one cycle.
module per_key_request_serializer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic                          req_bypass,
   input  logic [pkrs_pkg::KeyBits-1:0]  req_request_key,
   input  logic [pkrs_pkg::TagBits-1:0]  req_task_tag,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_action,
   output logic [pkrs_pkg::TagBits-1:0]  rsp_out_tag,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   localparam int NE = pkrs_pkg::NumEntries;
   localparam int QD = pkrs_pkg::QueueDepth;
   localparam int EB = pkrs_pkg::EntryBits;
   localparam int PB = pkrs_pkg::PtrBits;
   localparam int CB = pkrs_pkg::CntBits;
   localparam int AB = pkrs_pkg::ActBits;
   localparam int TB = pkrs_pkg::TagBits;

   logic [4:0] max_keys_ff;
   logic [3:0] max_per_ff;

   logic [NE-1:0]                          valid_ff;
   logic [NE-1:0][pkrs_pkg::KeyBits-1:0]   key_ff;
   // per-key tag queues, oldest tag always in slot 0
   logic [NE-1:0][QD-1:0][TB-1:0]          tags_ff;
   logic [NE-1:0][CB-1:0]                  count_ff;
   logic [AB-1:0]                          active_ff;

   // input register
   logic                         item_ff;
   logic                         op_ff, byp_ff;
   logic [pkrs_pkg::KeyBits-1:0] rkey_ff;
   logic [TB-1:0]                rtag_ff;

   // second result waiting
   logic          pend_ff;
   logic [TB-1:0] pend_tag_ff;

   logic rsp_valid_ff, rsp_last_ff;
   logic [2:0] rsp_action_ff;
   logic [TB-1:0] rsp_tag_ff;

   pkrs_pkg::lookup_type look;

   pkrs_lookup u_lookup (
      .valid (valid_ff),
      .keys  (key_ff),
      .key   (rkey_ff),
      .result(look)
   );

   assign pready = 1'b1;
   assign busy   = pend_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;
   assign rsp_out_tag = rsp_tag_ff;
   assign rsp_last   = rsp_last_ff;

   // csr read
   always_comb begin
      case (paddr[2])
         pkrs_pkg::REG_MAX_ACTIVE:  prdata = {27'd0, max_keys_ff};
         pkrs_pkg::REG_MAX_PER_KEY: prdata = {28'd0, max_per_ff};
         default:                   prdata = '0;
      endcase
   end

   // effective limits
   logic [AB-1:0] key_lim;
   logic [CB-1:0] q_lim;
   always_comb begin
      key_lim = (32'(max_keys_ff) > NE) ? AB'(NE) : AB'(max_keys_ff);
      q_lim   = (32'(max_per_ff) > QD) ? CB'(QD) : CB'(max_per_ff);
   end

   // per-item decode
   logic [EB-1:0] hi;
   logic [PB-1:0] tail;
   logic [CB-1:0] cnt;
   logic [TB-1:0] head_tag, next_tag;
   always_comb begin
      hi       = look.hit_idx;
      cnt      = count_ff[hi];
      tail     = cnt[PB-1:0];
      head_tag = tags_ff[hi][0];
      next_tag = tags_ff[hi][1];
   end

   // decision and next result
   logic          do_push, do_claim, do_free, do_pop;
   logic [2:0]    rsp_action_in;
   logic [TB-1:0] rsp_tag_in;
   logic          rsp_last_in, pend_in;
   always_comb begin
      do_push       = 1'b0;
      do_claim      = 1'b0;
      do_free       = 1'b0;
      do_pop        = 1'b0;
      rsp_action_in = pkrs_pkg::ACT_REPLY;
      rsp_tag_in    = pend_tag_ff;
      rsp_last_in   = 1'b1;
      pend_in       = 1'b0;
      if (pend_ff) begin
         // reply that follows a dispatch of the new head
         rsp_action_in = pkrs_pkg::ACT_REPLY;
      end else if (item_ff) begin
         rsp_tag_in = rtag_ff;
         if (byp_ff) begin
            rsp_action_in = (op_ff == pkrs_pkg::OP_COMPLETE) ?
                            pkrs_pkg::ACT_REPLY : pkrs_pkg::ACT_DISPATCH;
         end else if (op_ff == pkrs_pkg::OP_SUBMIT) begin
            if (look.hit) begin
               if (cnt < q_lim) begin
                  do_push       = 1'b1;
                  rsp_action_in = pkrs_pkg::ACT_HELD;
               end else begin
                  rsp_action_in = pkrs_pkg::ACT_REJ_KEY_FULL;
               end
            end else if (active_ff >= key_lim || !look.free) begin
               rsp_action_in = pkrs_pkg::ACT_REJ_NO_ENTRY;
            end else begin
               do_claim      = 1'b1;
               rsp_action_in = pkrs_pkg::ACT_DISPATCH;
            end
         end else if (!look.hit) begin
            rsp_action_in = pkrs_pkg::ACT_REPLY_UNKNWN;
         end else if (cnt == '0 || head_tag != rtag_ff) begin
            rsp_action_in = pkrs_pkg::ACT_REPLY_NOHEAD;
         end else if (cnt == CB'(1)) begin
            // last tag popped, entry freed
            do_free       = 1'b1;
            rsp_action_in = pkrs_pkg::ACT_REPLY;
         end else begin
            // pop, dispatch new head, reply follows
            do_pop        = 1'b1;
            rsp_action_in = pkrs_pkg::ACT_DISPATCH;
            rsp_tag_in    = next_tag;
            rsp_last_in   = 1'b0;
            pend_in       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_keys_ff  <= 5'd16;
         max_per_ff   <= 4'd8;
         valid_ff     <= '0;
         count_ff     <= '0;
         active_ff    <= '0;
         item_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // csr write transfer
         if (psel && penable && pwrite) begin
            case (paddr[2])
               pkrs_pkg::REG_MAX_ACTIVE:  max_keys_ff <= pwdata[4:0];
               pkrs_pkg::REG_MAX_PER_KEY: max_per_ff  <= pwdata[3:0];
               default: ;
            endcase
         end
         // input register, an item behind a second result stays put
         item_ff <= (start && !busy) || (item_ff && pend_ff);
         if (start && !busy) begin
            op_ff   <= req_operation;
            byp_ff  <= req_bypass;
            rkey_ff <= req_request_key;
            rtag_ff <= req_task_tag;
         end
         // result register
         rsp_valid_ff  <= pend_ff || item_ff;
         rsp_action_ff <= rsp_action_in;
         rsp_tag_ff    <= rsp_tag_in;
         rsp_last_ff   <= rsp_last_in;
         pend_ff       <= pend_in;
         if (pend_in) pend_tag_ff <= rtag_ff;
         // key table and queue updates
         if (do_push) begin
            tags_ff[hi][tail] <= rtag_ff;
            count_ff[hi]      <= cnt + CB'(1);
         end
         if (do_claim) begin
            valid_ff[look.free_idx]   <= 1'b1;
            key_ff[look.free_idx]     <= rkey_ff;
            count_ff[look.free_idx]   <= CB'(1);
            tags_ff[look.free_idx][0] <= rtag_ff;
            active_ff                 <= active_ff + AB'(1);
         end
         if (do_free) begin
            valid_ff[hi] <= 1'b0;
            count_ff[hi] <= '0;
            if (active_ff != '0) active_ff <= active_ff - AB'(1);
         end
         if (do_pop) begin
            for (int j = 0; j < QD - 1; j++) tags_ff[hi][j] <= tags_ff[hi][j+1];
            count_ff[hi] <= cnt - CB'(1);
         end
      end
   end
endmodule

FILE: verif/per_key_request_serializer_top_tb.sv
// testbench for the per-key request serializer: directed and random transfers, csr writes
// depends on pkrs_pkg and per_key_request_serializer_top
`timescale 1ns / 1ps

module per_key_request_serializer_top_tb;

   typedef struct {
      pkrs_pkg::action_type              act;
      logic [pkrs_pkg::TagBits-1:0]      tag;
      logic                              last;
   } verdict_type;

   // key table model and queue of expected verdicts
   class serializer_scoreboard;
      bit                            ent_valid [pkrs_pkg::NumEntries];
      bit [pkrs_pkg::KeyBits-1:0]    ent_key [pkrs_pkg::NumEntries];
      bit [pkrs_pkg::TagBits-1:0]    ent_tags [pkrs_pkg::NumEntries][pkrs_pkg::QueueDepth];
      int                            ent_head [pkrs_pkg::NumEntries];
      int                            ent_cnt [pkrs_pkg::NumEntries];
      int                            active;
      int                            max_keys;
      int                            max_depth;
      verdict_type                   pending_verdicts [$];
      int                            errors;

      function new();
         active = 0;
         max_keys = 16;
         max_depth = 8;
         errors = 0;
         foreach (ent_valid[i]) begin
            ent_valid[i] = 0;
            ent_head[i] = 0;
            ent_cnt[i] = 0;
         end
      endfunction

      function void push_verdict(pkrs_pkg::action_type a, logic [pkrs_pkg::TagBits-1:0] t,
                                 logic l);
         verdict_type v;
         v.act = a;
         v.tag = t;
         v.last = l;
         pending_verdicts.push_back(v);
      endfunction

      function int find_key(logic [pkrs_pkg::KeyBits-1:0] k);
         foreach (ent_valid[i])
            if (ent_valid[i] && ent_key[i] == k) return i;
         return -1;
      endfunction

      // head tag of a random occupied entry, for well-formed completions
      function bit pick_head(output logic [pkrs_pkg::KeyBits-1:0] k,
                             output logic [pkrs_pkg::TagBits-1:0] t);
         int start_idx;
         int e;
         start_idx = $urandom_range(pkrs_pkg::NumEntries - 1);
         for (int i = 0; i < pkrs_pkg::NumEntries; i++) begin
            e = (start_idx + i) % pkrs_pkg::NumEntries;
            if (ent_valid[e]) begin
               k = ent_key[e];
               t = ent_tags[e][ent_head[e]];
               return 1;
            end
         end
         return 0;
      endfunction

      // predict the verdicts of one accepted transfer
      function void note_request(logic op, logic byp, logic [pkrs_pkg::KeyBits-1:0] k,
                                 logic [pkrs_pkg::TagBits-1:0] t);
         int key_lim;
         int q_lim;
         int e;
         key_lim = (max_keys > pkrs_pkg::NumEntries) ? pkrs_pkg::NumEntries : max_keys;
         q_lim = (max_depth > pkrs_pkg::QueueDepth) ? pkrs_pkg::QueueDepth : max_depth;
         if (byp) begin
            push_verdict(op == pkrs_pkg::OP_COMPLETE ? pkrs_pkg::ACT_REPLY :
                         pkrs_pkg::ACT_DISPATCH, t, 1);
            return;
         end
         e = find_key(k);
         if (op == pkrs_pkg::OP_SUBMIT) begin
            if (e >= 0) begin
               if (ent_cnt[e] < q_lim) begin
                  ent_tags[e][(ent_head[e] + ent_cnt[e]) % pkrs_pkg::QueueDepth] = t;
                  ent_cnt[e]++;
                  push_verdict(pkrs_pkg::ACT_HELD, t, 1);
               end else begin
                  push_verdict(pkrs_pkg::ACT_REJ_KEY_FULL, t, 1);
               end
               return;
            end
            if (active >= key_lim) begin
               push_verdict(pkrs_pkg::ACT_REJ_NO_ENTRY, t, 1);
               return;
            end
            foreach (ent_valid[i])
               if (!ent_valid[i]) begin
                  ent_valid[i] = 1;
                  ent_key[i] = k;
                  ent_head[i] = 0;
                  ent_cnt[i] = 1;
                  ent_tags[i][0] = t;
                  active++;
                  push_verdict(pkrs_pkg::ACT_DISPATCH, t, 1);
                  return;
               end
            push_verdict(pkrs_pkg::ACT_REJ_NO_ENTRY, t, 1);
            return;
         end
         if (e < 0) begin
            push_verdict(pkrs_pkg::ACT_REPLY_UNKNWN, t, 1);
            return;
         end
         if (ent_cnt[e] == 0 || ent_tags[e][ent_head[e]] != t) begin
            push_verdict(pkrs_pkg::ACT_REPLY_NOHEAD, t, 1);
            return;
         end
         ent_head[e] = (ent_head[e] + 1) % pkrs_pkg::QueueDepth;
         ent_cnt[e]--;
         if (ent_cnt[e] == 0) begin
            ent_valid[e] = 0;
            ent_head[e] = 0;
            if (active > 0) active--;
            push_verdict(pkrs_pkg::ACT_REPLY, t, 1);
            return;
         end
         push_verdict(pkrs_pkg::ACT_DISPATCH, ent_tags[e][ent_head[e]], 0);
         push_verdict(pkrs_pkg::ACT_REPLY, t, 1);
      endfunction

      function void check_verdict(logic [2:0] a, logic [pkrs_pkg::TagBits-1:0] t, logic l);
         verdict_type v;
         if (pending_verdicts.size() == 0) begin
            $error("unexpected result: action %0d tag %0d last %0d", a, t, l);
            errors++;
            return;
         end
         v = pending_verdicts.pop_front();
         if (a !== v.act) begin
            $error("action: expected %0d, got %0d", v.act, a);
            errors++;
         end
         if (t !== v.tag) begin
            $error("out_tag: expected %0d, got %0d", v.tag, t);
            errors++;
         end
         if (l !== v.last) begin
            $error("last: expected %0d, got %0d", v.last, l);
            errors++;
         end
      endfunction
   endclass

   localparam int WatchdogLimit = 5000;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_operation;
   logic                          req_bypass;
   logic [pkrs_pkg::KeyBits-1:0]  req_request_key;
   logic [pkrs_pkg::TagBits-1:0]  req_task_tag;
   logic                          rsp_valid;
   logic [2:0]                    rsp_action;
   logic [pkrs_pkg::TagBits-1:0]  rsp_out_tag;
   logic                          rsp_last;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [2:0]                    paddr;
   logic [31:0]                   pwdata;
   logic [31:0]                   prdata;
   logic                          pready;

   serializer_scoreboard sb = new();
   logic [pkrs_pkg::KeyBits-1:0]  key_pool [20];
   int                            idle_cycles;

   per_key_request_serializer_top i_dut (.*);

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // result monitor
   always @(posedge clock)
      if (!reset && rsp_valid) sb.check_verdict(rsp_action, rsp_out_tag, rsp_last);

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // present one transfer and hold it until accepted; start stays high afterwards
   task automatic send_request(logic op, logic byp, logic [pkrs_pkg::KeyBits-1:0] k,
                               logic [pkrs_pkg::TagBits-1:0] t);
      start = 1'b1;
      req_operation = op;
      req_bypass = byp;
      req_request_key = k;
      req_task_tag = t;
      do @(posedge clock); while (busy);
      sb.note_request(op, byp, k, t);
      @(negedge clock);
   endtask

   task automatic idle(int n);
      start = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic random_gap(bit quiet);
      int r;
      r = $urandom_range(99);
      if (quiet || r < 60) return;
      if (r < 92) idle($urandom_range(1, 3));
      else idle($urandom_range(10, 40));
   endtask

   // let every expected result arrive, with start low
   task automatic drain();
      start = 1'b0;
      while (sb.pending_verdicts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [31:0] value);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (pready) begin
         if (idx == pkrs_pkg::REG_MAX_ACTIVE) sb.max_keys = value[4:0];
         else sb.max_depth = value[3:0];
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic set_limits(int keys, int depth);
      drain();
      write_csr(pkrs_pkg::REG_MAX_ACTIVE, keys);
      write_csr(pkrs_pkg::REG_MAX_PER_KEY, depth);
   endtask

   // mostly well-formed submits and head completions, some noise
   task automatic random_phase(int n);
      logic [pkrs_pkg::KeyBits-1:0] k;
      logic [pkrs_pkg::TagBits-1:0] t;
      int                           r;
      bit                           quiet;
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0) quiet = ($urandom_range(3) == 0);
         r = $urandom_range(99);
         k = key_pool[$urandom_range(19)];
         t = pkrs_pkg::TagBits'($urandom);
         if (r < 45) begin
            send_request(pkrs_pkg::OP_SUBMIT, 1'b0, k, t);
         end else if (r < 80) begin
            if (sb.pick_head(k, t)) send_request(pkrs_pkg::OP_COMPLETE, 1'b0, k, t);
            else send_request(pkrs_pkg::OP_SUBMIT, 1'b0, k, t);
         end else if (r < 88) begin
            send_request(pkrs_pkg::OP_COMPLETE, 1'b0,
                         ($urandom_range(1) ? k : pkrs_pkg::KeyBits'($urandom)), t);
         end else begin
            send_request(1'($urandom_range(1)), 1'b1, pkrs_pkg::KeyBits'($urandom), t);
         end
         random_gap(quiet);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_operation = pkrs_pkg::OP_SUBMIT;
      req_bypass = 1'b0;
      req_request_key = '0;
      req_task_tag = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 20; i++) key_pool[i] = pkrs_pkg::KeyBits'($urandom);
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: bypass both ways, field extremes, unknown and non-head completions
      send_request(pkrs_pkg::OP_SUBMIT, 1'b1, '1, 8'hff);
      send_request(pkrs_pkg::OP_COMPLETE, 1'b1, '0, 8'h00);
      send_request(pkrs_pkg::OP_COMPLETE, 1'b0, '1, 8'h12);
      send_request(pkrs_pkg::OP_SUBMIT, 1'b0, '0, 8'h00);
      send_request(pkrs_pkg::OP_SUBMIT, 1'b0, '1, 8'hff);
      send_request(pkrs_pkg::OP_SUBMIT, 1'b0, '0, 8'h55);
      send_request(pkrs_pkg::OP_SUBMIT, 1'b0, '0, 8'haa);
      send_request(pkrs_pkg::OP_COMPLETE, 1'b0, '0, 8'h55);
      send_request(pkrs_pkg::OP_COMPLETE, 1'b0, '0, 8'h00);
      send_request(pkrs_pkg::OP_COMPLETE, 1'b0, '0, 8'h55);
      send_request(pkrs_pkg::OP_COMPLETE, 1'b0, '0, 8'haa);
      send_request(pkrs_pkg::OP_COMPLETE, 1'b0, '1, 8'hff);
      // queue full on one key, then a second key refused by a limit of one key
      set_limits(1, 2);
      send_request(pkrs_pkg::OP_SUBMIT, 1'b0, 32'h1234, 8'h01);
      send_request(pkrs_pkg::OP_SUBMIT, 1'b0, 32'h1234, 8'h02);
      send_request(pkrs_pkg::OP_SUBMIT, 1'b0, 32'h1234, 8'h03);
      send_request(pkrs_pkg::OP_SUBMIT, 1'b0, 32'h5678, 8'h04);
      // zero limits with an entry still present
      set_limits(0, 0);
      send_request(pkrs_pkg::OP_SUBMIT, 1'b0, 32'h1234, 8'h05);
      send_request(pkrs_pkg::OP_SUBMIT, 1'b0, 32'h9abc, 8'h06);
      send_request(pkrs_pkg::OP_COMPLETE, 1'b0, 32'h1234, 8'h01);
      send_request(pkrs_pkg::OP_COMPLETE, 1'b0, 32'h1234, 8'h02);
      // limits above hardware size
      set_limits(31, 15);

      // random phases across several settings
      random_phase(400);
      set_limits(3, 2);
      random_phase(300);
      set_limits(0, 0);
      random_phase(150);
      set_limits(16, 8);
      random_phase(450);
      set_limits(1, 1);
      random_phase(250);
      set_limits(31, 15);
      random_phase(450);

      drain();
      if (sb.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

FILE: filelist.f
design/pkrs_pkg.sv
design/pkrs_lookup.sv
design/per_key_request_serializer_top.sv
verif/per_key_request_serializer_top_tb.sv
